// ===== hw/rtl/mbrv_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrv_pkg: shared types and constants of the request validator
// Request and response beat layouts, the register set, function codes,
// status codes, table codes and the quantity limits of the checks.
// ----------------------------------------------------------------------------
package mbrv_pkg;

   // register port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int COUNT_W    = 17;
   localparam int MASK_W     = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_COIL_COUNT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_BITS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_REGS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDING_REGS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_READ_ALLOWED  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_ALLOWED = 3'd5;

   // function codes
   localparam logic [7:0] FC_READ_COILS     = 8'd1;
   localparam logic [7:0] FC_READ_INPUTS    = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
   localparam logic [7:0] FC_READ_INREGS    = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
   localparam logic [7:0] FC_WRITE_REG      = 8'd6;
   localparam logic [7:0] FC_DIAGNOSTICS    = 8'd8;
   localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS     = 8'd16;
   localparam logic [7:0] FC_READ_WRITE_REGS = 8'd23;

   localparam logic [15:0] SUB_LOOPBACK = 16'd0;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ILL_FUNC  = 2'd1;
   localparam logic [1:0] ST_ILL_ADDR  = 2'd2;
   localparam logic [1:0] ST_ILL_VALUE = 2'd3;

   // table codes
   localparam logic [1:0] T_COILS   = 2'd0;
   localparam logic [1:0] T_INPUTS  = 2'd1;
   localparam logic [1:0] T_INREGS  = 2'd2;
   localparam logic [1:0] T_HOLDING = 2'd3;

   // quantity limits and special values
   localparam logic [15:0] LIM_READ_BITS   = 16'h07D0;
   localparam logic [15:0] LIM_READ_REGS   = 16'h007D;
   localparam logic [15:0] LIM_WRITE_BITS  = 16'h07B0;
   localparam logic [15:0] LIM_WRITE_REGS  = 16'h007B;
   localparam logic [15:0] LIM_RW_WRITE    = 16'h0079;
   localparam logic [15:0] COIL_ON         = 16'hFF00;

   // response lengths
   localparam logic [7:0] RLEN_EXCEPTION = 8'd2;
   localparam logic [7:0] RLEN_WRITE     = 8'd5;
   localparam logic [7:0] RLEN_READ_HDR  = 8'd2;
   localparam logic [8:0] PLEN_MULTI_HDR = 9'd6;
   localparam logic [8:0] PLEN_RW_HDR    = 9'd10;

   typedef struct packed {
      logic [7:0]  function_code;
      logic        is_broadcast;
      logic        newer_pending;
      logic [15:0] start_address;
      logic [15:0] item_quantity;
      logic [7:0]  byte_count;
      logic [7:0]  pdu_length;
      logic [15:0] single_value;
      logic [15:0] second_address;
      logic [15:0] second_quantity;
      logic [15:0] diag_subcode;
   } mbrv_req_type;

   typedef struct packed {
      logic        send_response;
      logic [1:0]  status;
      logic [7:0]  response_length;
      logic [1:0]  table_select;
      logic        write_enable;
      logic [15:0] write_start;
      logic [10:0] write_count;
      logic        coil_value;
      logic        read_enable;
      logic [15:0] read_start;
      logic [10:0] read_count;
      logic [7:0]  read_byte_count;
   } mbrv_rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] coil_count;
      logic [COUNT_W-1:0] input_bit_count;
      logic [COUNT_W-1:0] input_reg_count;
      logic [COUNT_W-1:0] holding_reg_count;
      logic [MASK_W-1:0]  read_allowed;
      logic [MASK_W-1:0]  write_allowed;
   } mbrv_cfg_type;

   // size of the table that a table code names
   function automatic logic [COUNT_W-1:0] table_size(mbrv_cfg_type cfg, logic [1:0] tsel);
      logic [COUNT_W-1:0] size;
      case (tsel)
         T_COILS:  size = cfg.coil_count;
         T_INPUTS: size = cfg.input_bit_count;
         T_INREGS: size = cfg.input_reg_count;
         default:  size = cfg.holding_reg_count;
      endcase
      return size;
   endfunction

endpackage

// ===== hw/rtl/mbrv_req_if.sv =====
// ----------------------------------------------------------------------------
// mbrv_req_if: request channel
// Valid/ready channel that carries one decoded request header per beat.
// ----------------------------------------------------------------------------
interface mbrv_req_if;
   logic                  valid;
   logic                  ready;
   mbrv_pkg::mbrv_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mbrv_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mbrv_rsp_if: response channel
// Valid/ready channel that carries one check result per beat.
// ----------------------------------------------------------------------------
interface mbrv_rsp_if;
   logic                  valid;
   logic                  ready;
   mbrv_pkg::mbrv_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mbrv_csr.sv =====
// ----------------------------------------------------------------------------
// mbrv_csr: configuration registers
// APB-style register file holding the table sizes and access masks.
// ----------------------------------------------------------------------------
module mbrv_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mbrv_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [mbrv_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [mbrv_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output mbrv_pkg::mbrv_cfg_type           cfg
);

   mbrv_pkg::mbrv_cfg_type            cfg_ff;
   mbrv_pkg::mbrv_cfg_type            cfg_in;
   logic [mbrv_pkg::CSR_IDX_W-1:0]    index;
   logic                              wr_en;

   assign pready = 1'b1;
   assign index  = paddr[mbrv_pkg::CSR_ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            mbrv_pkg::REG_COIL_COUNT:
               cfg_in.coil_count = pwdata[mbrv_pkg::COUNT_W-1:0];
            mbrv_pkg::REG_INPUT_BITS:
               cfg_in.input_bit_count = pwdata[mbrv_pkg::COUNT_W-1:0];
            mbrv_pkg::REG_INPUT_REGS:
               cfg_in.input_reg_count = pwdata[mbrv_pkg::COUNT_W-1:0];
            mbrv_pkg::REG_HOLDING_REGS:
               cfg_in.holding_reg_count = pwdata[mbrv_pkg::COUNT_W-1:0];
            mbrv_pkg::REG_READ_ALLOWED:
               cfg_in.read_allowed = pwdata[mbrv_pkg::MASK_W-1:0];
            mbrv_pkg::REG_WRITE_ALLOWED:
               cfg_in.write_allowed = pwdata[mbrv_pkg::MASK_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      unique case (index)
         mbrv_pkg::REG_COIL_COUNT:
            prdata = {{(mbrv_pkg::CSR_DATA_W-mbrv_pkg::COUNT_W){1'b0}}, cfg_ff.coil_count};
         mbrv_pkg::REG_INPUT_BITS:
            prdata = {{(mbrv_pkg::CSR_DATA_W-mbrv_pkg::COUNT_W){1'b0}},
                      cfg_ff.input_bit_count};
         mbrv_pkg::REG_INPUT_REGS:
            prdata = {{(mbrv_pkg::CSR_DATA_W-mbrv_pkg::COUNT_W){1'b0}},
                      cfg_ff.input_reg_count};
         mbrv_pkg::REG_HOLDING_REGS:
            prdata = {{(mbrv_pkg::CSR_DATA_W-mbrv_pkg::COUNT_W){1'b0}},
                      cfg_ff.holding_reg_count};
         mbrv_pkg::REG_READ_ALLOWED:
            prdata = {{(mbrv_pkg::CSR_DATA_W-mbrv_pkg::MASK_W){1'b0}}, cfg_ff.read_allowed};
         mbrv_pkg::REG_WRITE_ALLOWED:
            prdata = {{(mbrv_pkg::CSR_DATA_W-mbrv_pkg::MASK_W){1'b0}}, cfg_ff.write_allowed};
         default: begin
            prdata = '0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/mbrv_check.sv =====
// ----------------------------------------------------------------------------
// mbrv_check: request header checks
// Runs the per-function checks in order and builds the table commands and
// the response length for one registered request header.
// ----------------------------------------------------------------------------
module mbrv_check (
   input  mbrv_pkg::mbrv_cfg_type cfg,
   input  mbrv_pkg::mbrv_req_type req,
   output mbrv_pkg::mbrv_rsp_type rsp
);

   localparam int CW = mbrv_pkg::COUNT_W;

   logic [CW-1:0] addr_ext;
   logic [CW-1:0] qty_ext;
   logic [CW-1:0] raddr_ext;
   logic [CW-1:0] rqty_ext;
   logic [CW-1:0] cnt_ext;
   logic [CW-1:0] wr_end;
   logic [CW-1:0] rd_end;
   logic [CW-1:0] bit_bytes;
   logic [CW-1:0] reg_bytes;
   logic [CW-1:0] rreg_bytes;
   logic [8:0]    plen_ext;
   logic [8:0]    multi_plen;
   logic [8:0]    rw_plen;
   logic [CW-1:0] size_sel;
   logic [1:0]    tsel;
   logic          bits;

   // operand widening and the shared sums
   assign addr_ext   = {1'b0, req.start_address};
   assign qty_ext    = {1'b0, req.item_quantity};
   assign raddr_ext  = {1'b0, req.second_address};
   assign rqty_ext   = {1'b0, req.second_quantity};
   assign cnt_ext    = {{(CW-8){1'b0}}, req.byte_count};
   assign wr_end     = addr_ext + qty_ext;
   assign rd_end     = raddr_ext + rqty_ext;
   assign bit_bytes  = (qty_ext + CW'(7)) >> 3;
   assign reg_bytes  = {qty_ext[CW-2:0], 1'b0};
   assign rreg_bytes = {rqty_ext[CW-2:0], 1'b0};
   assign plen_ext   = {1'b0, req.pdu_length};
   assign multi_plen = mbrv_pkg::PLEN_MULTI_HDR + {1'b0, req.byte_count};
   assign rw_plen    = mbrv_pkg::PLEN_RW_HDR + {1'b0, req.byte_count};

   // table named by the function code
   always_comb begin
      tsel = mbrv_pkg::T_COILS;
      bits = 1'b0;
      case (req.function_code) inside
         mbrv_pkg::FC_READ_COILS, mbrv_pkg::FC_WRITE_COILS: begin
            tsel = mbrv_pkg::T_COILS;
            bits = 1'b1;
         end
         mbrv_pkg::FC_WRITE_COIL: begin
            tsel = mbrv_pkg::T_COILS;
         end
         mbrv_pkg::FC_READ_INPUTS: begin
            tsel = mbrv_pkg::T_INPUTS;
            bits = 1'b1;
         end
         mbrv_pkg::FC_READ_INREGS: begin
            tsel = mbrv_pkg::T_INREGS;
         end
         mbrv_pkg::FC_READ_HOLDING, mbrv_pkg::FC_WRITE_REG, mbrv_pkg::FC_WRITE_REGS,
         mbrv_pkg::FC_READ_WRITE_REGS: begin
            tsel = mbrv_pkg::T_HOLDING;
         end
         default: begin
            tsel = mbrv_pkg::T_COILS;
         end
      endcase
   end

   assign size_sel = mbrv_pkg::table_size(cfg, tsel);

   // checks in order, first failure wins
   always_comb begin
      rsp = '0;
      if (req.pdu_length != 8'd0) begin
         rsp.send_response = !req.is_broadcast && !req.newer_pending;
         rsp.table_select  = tsel;
         rsp.status        = mbrv_pkg::ST_OK;
         case (req.function_code) inside
            mbrv_pkg::FC_READ_COILS, mbrv_pkg::FC_READ_INPUTS,
            mbrv_pkg::FC_READ_HOLDING, mbrv_pkg::FC_READ_INREGS: begin
               if (!req.is_broadcast) begin
                  if (req.item_quantity == 16'd0 || req.item_quantity >
                      (bits ? mbrv_pkg::LIM_READ_BITS : mbrv_pkg::LIM_READ_REGS)) begin
                     rsp.status = mbrv_pkg::ST_ILL_VALUE;
                  end else if (wr_end > size_sel) begin
                     rsp.status = mbrv_pkg::ST_ILL_ADDR;
                  end else if (!cfg.read_allowed[tsel]) begin
                     rsp.status = mbrv_pkg::ST_ILL_FUNC;
                  end else begin
                     rsp.read_enable     = 1'b1;
                     rsp.read_start      = req.start_address;
                     rsp.read_count      = req.item_quantity[10:0];
                     rsp.read_byte_count = bits ? bit_bytes[7:0] : reg_bytes[7:0];
                     rsp.response_length = mbrv_pkg::RLEN_READ_HDR +
                                           (bits ? bit_bytes[7:0] : reg_bytes[7:0]);
                  end
               end
            end
            mbrv_pkg::FC_WRITE_COIL: begin
               if (req.single_value != 16'd0 && req.single_value != mbrv_pkg::COIL_ON) begin
                  rsp.status = mbrv_pkg::ST_ILL_VALUE;
               end else if (addr_ext >= cfg.coil_count) begin
                  rsp.status = mbrv_pkg::ST_ILL_ADDR;
               end else if (!cfg.write_allowed[mbrv_pkg::T_COILS]) begin
                  rsp.status = mbrv_pkg::ST_ILL_FUNC;
               end else begin
                  rsp.write_enable    = 1'b1;
                  rsp.write_start     = req.start_address;
                  rsp.write_count     = 11'd1;
                  rsp.coil_value      = (req.single_value == mbrv_pkg::COIL_ON);
                  rsp.response_length = mbrv_pkg::RLEN_WRITE;
               end
            end
            mbrv_pkg::FC_WRITE_REG: begin
               if (addr_ext >= cfg.holding_reg_count) begin
                  rsp.status = mbrv_pkg::ST_ILL_ADDR;
               end else if (!cfg.write_allowed[mbrv_pkg::T_HOLDING]) begin
                  rsp.status = mbrv_pkg::ST_ILL_FUNC;
               end else begin
                  rsp.write_enable    = 1'b1;
                  rsp.write_start     = req.start_address;
                  rsp.write_count     = 11'd1;
                  rsp.response_length = mbrv_pkg::RLEN_WRITE;
               end
            end
            mbrv_pkg::FC_WRITE_COILS, mbrv_pkg::FC_WRITE_REGS: begin
               if (req.item_quantity == 16'd0 || req.item_quantity >
                   (bits ? mbrv_pkg::LIM_WRITE_BITS : mbrv_pkg::LIM_WRITE_REGS)) begin
                  rsp.status = mbrv_pkg::ST_ILL_VALUE;
               end else if ((bits ? bit_bytes : reg_bytes) != cnt_ext) begin
                  rsp.status = mbrv_pkg::ST_ILL_VALUE;
               end else if (wr_end > size_sel) begin
                  rsp.status = mbrv_pkg::ST_ILL_ADDR;
               end else if (plen_ext != multi_plen) begin
                  rsp.status = mbrv_pkg::ST_ILL_VALUE;
               end else if (!cfg.write_allowed[tsel]) begin
                  rsp.status = mbrv_pkg::ST_ILL_FUNC;
               end else begin
                  rsp.write_enable    = 1'b1;
                  rsp.write_start     = req.start_address;
                  rsp.write_count     = req.item_quantity[10:0];
                  rsp.response_length = mbrv_pkg::RLEN_WRITE;
               end
            end
            mbrv_pkg::FC_READ_WRITE_REGS: begin
               if (req.item_quantity == 16'd0 ||
                   req.item_quantity > mbrv_pkg::LIM_RW_WRITE) begin
                  rsp.status = mbrv_pkg::ST_ILL_VALUE;
               end else if (reg_bytes != cnt_ext) begin
                  rsp.status = mbrv_pkg::ST_ILL_VALUE;
               end else if (wr_end > cfg.holding_reg_count) begin
                  rsp.status = mbrv_pkg::ST_ILL_ADDR;
               end else if (plen_ext != rw_plen) begin
                  rsp.status = mbrv_pkg::ST_ILL_VALUE;
               end else if (!cfg.write_allowed[mbrv_pkg::T_HOLDING]) begin
                  rsp.status = mbrv_pkg::ST_ILL_FUNC;
               end else if (req.second_quantity == 16'd0 ||
                            req.second_quantity > mbrv_pkg::LIM_READ_REGS) begin
                  rsp.status = mbrv_pkg::ST_ILL_VALUE;
               end else if (rd_end > cfg.holding_reg_count) begin
                  rsp.status = mbrv_pkg::ST_ILL_ADDR;
               end else if (!cfg.read_allowed[mbrv_pkg::T_HOLDING]) begin
                  rsp.status = mbrv_pkg::ST_ILL_FUNC;
               end else begin
                  rsp.write_enable    = 1'b1;
                  rsp.write_start     = req.start_address;
                  rsp.write_count     = req.item_quantity[10:0];
                  rsp.read_enable     = 1'b1;
                  rsp.read_start      = req.second_address;
                  rsp.read_count      = req.second_quantity[10:0];
                  rsp.read_byte_count = rreg_bytes[7:0];
                  rsp.response_length = mbrv_pkg::RLEN_READ_HDR + rreg_bytes[7:0];
               end
            end
            mbrv_pkg::FC_DIAGNOSTICS: begin
               // only loopback is answered, echoing the request length
               if (req.diag_subcode == mbrv_pkg::SUB_LOOPBACK) begin
                  rsp.response_length = req.pdu_length;
               end else begin
                  rsp.status = mbrv_pkg::ST_ILL_FUNC;
               end
            end
            default: begin
               rsp.status = mbrv_pkg::ST_ILL_FUNC;
            end
         endcase
         // exceptions always answer with two bytes
         if (rsp.status != mbrv_pkg::ST_OK) begin
            rsp.response_length = mbrv_pkg::RLEN_EXCEPTION;
         end
      end
   end

endmodule

// ===== hw/rtl/modbus_request_validator_core.sv =====
// ----------------------------------------------------------------------------
// modbus_request_validator_core: request header validator
// Checks decoded request headers against table sizes and access masks.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one decoded request header per beat, rsp_chan one
//   result per beat (status, response length, table read and write
//   commands, send flag). Every request beat gives exactly one result beat,
//   in order.
//   Table sizes and read/write masks sit in six 32-bit registers on the
//   APB-style port at byte addresses 0x00 to 0x14; pready is always high.
//   Change them only while no request is in flight.
//   One register holds the request, the checks run combinationally on it,
//   and a second register holds the result. Throughput is one beat per
//   cycle while the receiver takes results, set by the single check stage.
//   When the receiver stalls, the result register holds and the request
//   register keeps taking a beat until both are full; ready then drops.
//   Reset empties both stages and clears all six table and mask registers to
//   zero, which makes every table empty and every access refused.
// ----------------------------------------------------------------------------
module modbus_request_validator_core (
   input  logic                            clock,
   input  logic                            reset,
   mbrv_req_if.sink                        req_chan,
   mbrv_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mbrv_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mbrv_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mbrv_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   mbrv_pkg::mbrv_cfg_type cfg;
   mbrv_pkg::mbrv_req_type req_ff;
   mbrv_pkg::mbrv_req_type req_in;
   mbrv_pkg::mbrv_rsp_type rsp_ff;
   mbrv_pkg::mbrv_rsp_type rsp_in;
   mbrv_pkg::mbrv_rsp_type check_rsp;
   logic                   req_valid_ff;
   logic                   req_valid_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_open;
   logic                   req_open;

   mbrv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mbrv_check u_check (
      .cfg (cfg),
      .req (req_ff),
      .rsp (check_rsp)
   );

   // advance a stage when the one after it is free or draining
   assign rsp_open       = !rsp_valid_ff || rsp_chan.ready;
   assign req_open       = !req_valid_ff || rsp_open;
   assign req_chan.ready = req_open;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_open) begin
         req_valid_in = req_chan.valid;
         if (req_chan.valid) begin
            req_in = req_chan.payload;
         end
      end
      if (rsp_open) begin
         rsp_valid_in = req_valid_ff;
         if (req_valid_ff) begin
            rsp_in = check_rsp;
         end
      end
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== sim/tb_modbus_request_validator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modbus_request_validator_core: self-checking bench of the request validator
// Drives request headers in bursts while the result side stalls in its own
// pattern. Each accepted header is judged by its directed verdict or a local
// model of the checks, and each result beat is compared field by field in
// order. A short table of directed headers runs first under fixed table
// settings, then random phases run under random and extreme register settings.
// ----------------------------------------------------------------------------
module tb_modbus_request_validator_core;
   import mbrv_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 128;
   localparam int REPORT_LIMIT   = 10;

   // codes outside the supported set
   localparam logic [7:0] FC_VENDOR = 8'd43;
   localparam logic [7:0] FC_TOP    = 8'hFF;

   localparam logic [7:0] KNOWN_CODES [10] = '{FC_READ_COILS, FC_READ_INPUTS,
      FC_READ_HOLDING, FC_READ_INREGS, FC_WRITE_COIL, FC_WRITE_REG, FC_DIAGNOSTICS,
      FC_WRITE_COILS, FC_WRITE_REGS, FC_READ_WRITE_REGS};

   typedef struct {
      int           cfg_sel;
      mbrv_req_type hdr;
      bit           known;
      mbrv_rsp_type verdict;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   mbrv_req_if req_chan ();
   mbrv_rsp_if rsp_chan ();

   mbrv_cfg_type  table_cfg;
   mbrv_cfg_type  cfg_sets [4];
   mbrv_rsp_type  verdict_q [$];
   mbrv_rsp_type  verdict_now;
   dir_row_type   dir_rows [$];
   int            mismatches;
   int            headers_sent;
   int            results_seen;
   int            settings_applied;
   int            status_seen [4];
   int            stalled_cycles = 0;
   logic [10:0]   stall_tick = '0;

   modbus_request_validator_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // size of one table under a setting
   function automatic int unsigned table_count(mbrv_cfg_type c, logic [1:0] tsel);
      int unsigned n;
      case (tsel)
         T_COILS:  n = c.coil_count;
         T_INPUTS: n = c.input_bit_count;
         T_INREGS: n = c.input_reg_count;
         default:  n = c.holding_reg_count;
      endcase
      return n;
   endfunction

   // table that a read code names
   function automatic logic [1:0] read_table(logic [7:0] fc);
      logic [1:0] t;
      case (fc)
         FC_READ_COILS:   t = T_COILS;
         FC_READ_INPUTS:  t = T_INPUTS;
         FC_READ_HOLDING: t = T_HOLDING;
         default:         t = T_INREGS;
      endcase
      return t;
   endfunction

   // judge one header against the table settings, in the order of the checks
   function automatic mbrv_rsp_type judge_request(mbrv_cfg_type c, mbrv_req_type h);
      mbrv_rsp_type r;
      logic [1:0]   st;
      logic         bits;
      int unsigned  addr, qty, cnt, plen, raddr, rqty, lim, nbytes;
      r     = '0;
      st    = ST_OK;
      addr  = h.start_address;
      qty   = h.item_quantity;
      cnt   = h.byte_count;
      plen  = h.pdu_length;
      raddr = h.second_address;
      rqty  = h.second_quantity;
      // nothing received: all fields stay zero
      if (plen == 0) return r;
      case (h.function_code)
         FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING, FC_READ_INREGS: begin
            bits = (h.function_code == FC_READ_COILS) || (h.function_code == FC_READ_INPUTS);
            lim = bits ? LIM_READ_BITS : LIM_READ_REGS;
            r.table_select = read_table(h.function_code);
            // a broadcast read does nothing at all
            if (!h.is_broadcast) begin
               if (qty == 0 || qty > lim) st = ST_ILL_VALUE;
               else if (addr + qty > table_count(c, r.table_select)) st = ST_ILL_ADDR;
               else if (!c.read_allowed[r.table_select]) st = ST_ILL_FUNC;
               else begin
                  nbytes = bits ? (qty + 7) / 8 : 2 * qty;
                  r.read_enable     = 1'b1;
                  r.read_start      = h.start_address;
                  r.read_count      = 11'(qty);
                  r.read_byte_count = 8'(nbytes);
                  r.response_length = 8'(RLEN_READ_HDR + nbytes);
               end
            end
         end
         FC_WRITE_COIL: begin
            r.table_select = T_COILS;
            if (h.single_value != 16'h0 && h.single_value != COIL_ON) st = ST_ILL_VALUE;
            else if (addr >= c.coil_count) st = ST_ILL_ADDR;
            else if (!c.write_allowed[T_COILS]) st = ST_ILL_FUNC;
            else begin
               r.write_enable    = 1'b1;
               r.write_start     = h.start_address;
               r.write_count     = 11'd1;
               r.coil_value      = (h.single_value == COIL_ON);
               r.response_length = RLEN_WRITE;
            end
         end
         FC_WRITE_REG: begin
            r.table_select = T_HOLDING;
            if (addr >= c.holding_reg_count) st = ST_ILL_ADDR;
            else if (!c.write_allowed[T_HOLDING]) st = ST_ILL_FUNC;
            else begin
               r.write_enable    = 1'b1;
               r.write_start     = h.start_address;
               r.write_count     = 11'd1;
               r.response_length = RLEN_WRITE;
            end
         end
         FC_WRITE_COILS, FC_WRITE_REGS: begin
            bits = (h.function_code == FC_WRITE_COILS);
            lim = bits ? LIM_WRITE_BITS : LIM_WRITE_REGS;
            nbytes = bits ? (qty + 7) / 8 : 2 * qty;
            r.table_select = bits ? T_COILS : T_HOLDING;
            if (qty == 0 || qty > lim) st = ST_ILL_VALUE;
            else if (nbytes != cnt) st = ST_ILL_VALUE;
            else if (addr + qty > table_count(c, r.table_select)) st = ST_ILL_ADDR;
            else if (plen != PLEN_MULTI_HDR + cnt) st = ST_ILL_VALUE;
            else if (!c.write_allowed[r.table_select]) st = ST_ILL_FUNC;
            else begin
               r.write_enable    = 1'b1;
               r.write_start     = h.start_address;
               r.write_count     = 11'(qty);
               r.response_length = RLEN_WRITE;
            end
         end
         FC_READ_WRITE_REGS: begin
            r.table_select = T_HOLDING;
            if (qty == 0 || qty > LIM_RW_WRITE) st = ST_ILL_VALUE;
            else if (2 * qty != cnt) st = ST_ILL_VALUE;
            else if (addr + qty > c.holding_reg_count) st = ST_ILL_ADDR;
            else if (plen != PLEN_RW_HDR + cnt) st = ST_ILL_VALUE;
            else if (!c.write_allowed[T_HOLDING]) st = ST_ILL_FUNC;
            else if (rqty == 0 || rqty > LIM_READ_REGS) st = ST_ILL_VALUE;
            else if (raddr + rqty > c.holding_reg_count) st = ST_ILL_ADDR;
            else if (!c.read_allowed[T_HOLDING]) st = ST_ILL_FUNC;
            else begin
               r.write_enable    = 1'b1;
               r.write_start     = h.start_address;
               r.write_count     = 11'(qty);
               r.read_enable     = 1'b1;
               r.read_start      = h.second_address;
               r.read_count      = 11'(rqty);
               r.read_byte_count = 8'(2 * rqty);
               r.response_length = 8'(RLEN_READ_HDR + 2 * rqty);
            end
         end
         FC_DIAGNOSTICS: begin
            // only loopback is answered, echoing the whole request
            if (h.diag_subcode == SUB_LOOPBACK) r.response_length = h.pdu_length;
            else st = ST_ILL_FUNC;
         end
         default: st = ST_ILL_FUNC;
      endcase
      if (st != ST_OK) r.response_length = RLEN_EXCEPTION;
      r.status        = st;
      r.send_response = !h.is_broadcast && !h.newer_pending;
      return r;
   endfunction

   function automatic mbrv_req_type header_of(logic [7:0] fc, bit bc, bit np,
         int unsigned addr, int unsigned qty, int unsigned cnt, int unsigned plen,
         int unsigned val, int unsigned raddr, int unsigned rqty, int unsigned sub);
      mbrv_req_type h;
      h.function_code   = fc;
      h.is_broadcast    = bc;
      h.newer_pending   = np;
      h.start_address   = 16'(addr);
      h.item_quantity   = 16'(qty);
      h.byte_count      = 8'(cnt);
      h.pdu_length      = 8'(plen);
      h.single_value    = 16'(val);
      h.second_address  = 16'(raddr);
      h.second_quantity = 16'(rqty);
      h.diag_subcode    = 16'(sub);
      return h;
   endfunction

   // exception result: only send flag, status, response length and table differ from zero
   function automatic mbrv_rsp_type fault(bit send, logic [1:0] st, logic [1:0] tsel);
      mbrv_rsp_type r;
      r                 = '0;
      r.send_response   = send;
      r.status          = st;
      r.response_length = RLEN_EXCEPTION;
      r.table_select    = tsel;
      return r;
   endfunction

   // quantity near the limit, past it, zero or anywhere
   function automatic logic [15:0] pick_quantity(int unsigned lim);
      logic [15:0] q;
      case ($urandom_range(0, 9))
         0:       q = 16'h0;
         1:       q = 16'(lim);
         2:       q = 16'(lim + 1);
         3:       q = 16'($urandom);
         default: q = 16'($urandom_range(1, lim));
      endcase
      return q;
   endfunction

   // start address that mostly keeps the range inside the table
   function automatic logic [15:0] pick_address(int unsigned size, int unsigned qty);
      int unsigned top;
      if (size >= qty && $urandom_range(0, 7) != 0) begin
         top = size - qty;
         if (top > 16'hFFFF) top = 16'hFFFF;
         return ($urandom_range(0, 3) == 0) ? 16'(top) : 16'($urandom_range(0, top));
      end
      return 16'($urandom);
   endfunction

   // mostly well-formed headers with random content, the rest noise
   function automatic mbrv_req_type build_request(mbrv_cfg_type c);
      mbrv_req_type h;
      int unsigned  lim;
      logic         bits;
      h = $bits(mbrv_req_type)'({$urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(0, 4) == 0) begin
         if ($urandom_range(0, 1) == 0) h.function_code = KNOWN_CODES[$urandom_range(0, 9)];
         if ($urandom_range(0, 7) == 0) h.pdu_length = 8'h0;
         return h;
      end
      h.function_code = KNOWN_CODES[$urandom_range(0, 9)];
      h.is_broadcast  = ($urandom_range(0, 9) == 0);
      h.newer_pending = ($urandom_range(0, 9) == 0);
      case (h.function_code)
         FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING, FC_READ_INREGS: begin
            bits = (h.function_code == FC_READ_COILS) || (h.function_code == FC_READ_INPUTS);
            h.item_quantity = pick_quantity(bits ? LIM_READ_BITS : LIM_READ_REGS);
            h.start_address = pick_address(table_count(c, read_table(h.function_code)),
                                           h.item_quantity);
         end
         FC_WRITE_COIL: begin
            case ($urandom_range(0, 3))
               0:       h.single_value = 16'h0;
               1, 2:    h.single_value = COIL_ON;
               default: ;
            endcase
            h.start_address = pick_address(c.coil_count, 1);
         end
         FC_WRITE_REG: h.start_address = pick_address(c.holding_reg_count, 1);
         FC_WRITE_COILS, FC_WRITE_REGS: begin
            bits = (h.function_code == FC_WRITE_COILS);
            lim = bits ? LIM_WRITE_BITS : LIM_WRITE_REGS;
            h.item_quantity = pick_quantity(lim);
            if ($urandom_range(0, 9) != 0)
               h.byte_count = bits ? 8'((h.item_quantity + 7) / 8) : 8'(2 * h.item_quantity);
            h.start_address = pick_address(bits ? c.coil_count : c.holding_reg_count,
                                           h.item_quantity);
            if ($urandom_range(0, 9) != 0) h.pdu_length = 8'(PLEN_MULTI_HDR + h.byte_count);
         end
         FC_READ_WRITE_REGS: begin
            h.item_quantity = pick_quantity(LIM_RW_WRITE);
            if ($urandom_range(0, 9) != 0) h.byte_count = 8'(2 * h.item_quantity);
            h.start_address = pick_address(c.holding_reg_count, h.item_quantity);
            if ($urandom_range(0, 9) != 0) h.pdu_length = 8'(PLEN_RW_HDR + h.byte_count);
            h.second_quantity = pick_quantity(LIM_READ_REGS);
            h.second_address  = pick_address(c.holding_reg_count, h.second_quantity);
         end
         default: if ($urandom_range(0, 4) != 0) h.diag_subcode = SUB_LOOPBACK;
      endcase
      if (h.pdu_length == 8'h0) h.pdu_length = 8'(PLEN_MULTI_HDR);
      return h;
   endfunction

   // table size drawn from empty, tiny, mid, full and oversized
   function automatic logic [COUNT_W-1:0] random_count();
      logic [COUNT_W-1:0] n;
      case ($urandom_range(0, 6))
         0:       n = '0;
         1:       n = COUNT_W'($urandom_range(1, 16));
         2:       n = COUNT_W'($urandom_range(0, 2500));
         3:       n = COUNT_W'(16'hFFFF);
         4:       n = COUNT_W'(17'h10000);
         5:       n = COUNT_W'($urandom);
         default: n = COUNT_W'($urandom_range(60000, 17'h10000));
      endcase
      return n;
   endfunction

   function automatic string field_diffs(mbrv_rsp_type w, mbrv_rsp_type g);
      string s;
      s = "";
      if (w.send_response !== g.send_response)
         s = {s, $sformatf(" send_response %0h/%0h", w.send_response, g.send_response)};
      if (w.status !== g.status)
         s = {s, $sformatf(" status %0h/%0h", w.status, g.status)};
      if (w.response_length !== g.response_length)
         s = {s, $sformatf(" response_length %0h/%0h", w.response_length, g.response_length)};
      if (w.table_select !== g.table_select)
         s = {s, $sformatf(" table_select %0h/%0h", w.table_select, g.table_select)};
      if (w.write_enable !== g.write_enable)
         s = {s, $sformatf(" write_enable %0h/%0h", w.write_enable, g.write_enable)};
      if (w.write_start !== g.write_start)
         s = {s, $sformatf(" write_start %0h/%0h", w.write_start, g.write_start)};
      if (w.write_count !== g.write_count)
         s = {s, $sformatf(" write_count %0h/%0h", w.write_count, g.write_count)};
      if (w.coil_value !== g.coil_value)
         s = {s, $sformatf(" coil_value %0h/%0h", w.coil_value, g.coil_value)};
      if (w.read_enable !== g.read_enable)
         s = {s, $sformatf(" read_enable %0h/%0h", w.read_enable, g.read_enable)};
      if (w.read_start !== g.read_start)
         s = {s, $sformatf(" read_start %0h/%0h", w.read_start, g.read_start)};
      if (w.read_count !== g.read_count)
         s = {s, $sformatf(" read_count %0h/%0h", w.read_count, g.read_count)};
      if (w.read_byte_count !== g.read_byte_count)
         s = {s, $sformatf(" read_byte_count %0h/%0h", w.read_byte_count, g.read_byte_count)};
      return s;
   endfunction

   task automatic note_mismatch(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t mismatch:%s", $realtime, what);
   endtask

   // register port: setup then access, psel stays high across a sequence
   task automatic csr_write(int idx, logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx * 4);
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic csr_read(int idx, output logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'(idx * 4);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
   endtask

   // write every register, then read each one back
   task automatic apply_config(mbrv_cfg_type c);
      logic [CSR_DATA_W-1:0] want [REG_WRITE_ALLOWED+1];
      logic [CSR_DATA_W-1:0] got;
      want[REG_COIL_COUNT]    = CSR_DATA_W'(c.coil_count);
      want[REG_INPUT_BITS]    = CSR_DATA_W'(c.input_bit_count);
      want[REG_INPUT_REGS]    = CSR_DATA_W'(c.input_reg_count);
      want[REG_HOLDING_REGS]  = CSR_DATA_W'(c.holding_reg_count);
      want[REG_READ_ALLOWED]  = CSR_DATA_W'(c.read_allowed);
      want[REG_WRITE_ALLOWED] = CSR_DATA_W'(c.write_allowed);
      for (int i = REG_COIL_COUNT; i <= REG_WRITE_ALLOWED; i++) csr_write(i, want[i]);
      table_cfg = c;
      for (int i = REG_COIL_COUNT; i <= REG_WRITE_ALLOWED; i++) begin
         csr_read(i, got);
         if (got !== want[i])
            note_mismatch($sformatf(" register %0d reads %0h, written %0h", i, got, want[i]));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      settings_applied++;
   endtask

   // offer one header and hold it until the beat is taken
   task automatic offer_header(mbrv_req_type h, bit known, mbrv_rsp_type want);
      req_chan.valid   <= 1'b1;
      req_chan.payload <= h;
      do @(posedge clock); while (!req_chan.ready);
      verdict_q.push_back(known ? want : judge_request(table_cfg, h));
      headers_sent++;
   endtask

   // drop valid and hold until every result is back
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (verdict_q.size() != 0);
   endtask

   // result side: stall pattern chosen by the top two bits of stall_tick
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1'b1;
      case (stall_tick[10:9])
         2'd0:    rsp_chan.ready <= 1'b1;
         2'd1:    rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_chan.ready <= (stall_tick[1:0] == 2'd0);
         default: rsp_chan.ready <= $urandom_range(0, 1);
      endcase
   end

   // compare each result beat with the oldest verdict
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         status_seen[rsp_chan.payload.status]++;
         if (verdict_q.size() == 0) begin
            note_mismatch($sformatf(" result %h with nothing expected", rsp_chan.payload));
         end else begin
            verdict_now = verdict_q.pop_front();
            if (verdict_now !== rsp_chan.payload)
               note_mismatch($sformatf(" exp %h got %h, exp/got:%s", verdict_now,
                  rsp_chan.payload, field_diffs(verdict_now, rsp_chan.payload)));
         end
      end
   end

   // end the run when no beat moves for too long
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat for %0d cycles, %0d results pending",
                  stalled_cycles, verdict_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      int cur_sel;
      int burst_left;
      int gap;
      bit calm;
      mbrv_cfg_type c;

      mismatches       = 0;
      headers_sent     = 0;
      results_seen     = 0;
      settings_applied = 0;
      status_seen      = '{0, 0, 0, 0};
      table_cfg        = '0;
      reset            <= 1'b1;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;

      // settings of the directed part: reset, roomy, restricted, oversized
      cfg_sets[0] = '0;
      cfg_sets[1] = '{17'd100, 17'd2000, 17'd125, 17'h10000, 4'hF, 4'hF};
      cfg_sets[2] = '{17'h10000, 17'd0, 17'h10000, 17'd300, 4'b0101, 4'b0010};
      cfg_sets[3] = '{17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 4'h0, 4'hF};

      // all tables empty after reset
      dir_rows.push_back('{0, header_of(FC_READ_COILS, 0, 0, 0, 1, 0, 5, 0, 0, 0, 0),
                           1, fault(1, ST_ILL_ADDR, T_COILS)});
      dir_rows.push_back('{0, header_of(FC_WRITE_REG, 0, 0, 0, 0, 0, 5, 0, 0, 0, 0),
                           1, fault(1, ST_ILL_ADDR, T_HOLDING)});
      dir_rows.push_back('{0, header_of(FC_READ_HOLDING, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0),
                           1, mbrv_rsp_type'(0)});
      dir_rows.push_back('{0, header_of(FC_DIAGNOSTICS, 0, 0, 0, 0, 0, 5, 0, 0, 0, 0),
                           0, mbrv_rsp_type'(0)});
      // quantity limits, broadcast read, coil values, multi-writes, read/write
      dir_rows.push_back('{1, header_of(FC_READ_INPUTS, 0, 0, 0, 2000, 0, 5, 0, 0, 0, 0),
                           0, mbrv_rsp_type'(0)});
      dir_rows.push_back('{1, header_of(FC_READ_INPUTS, 0, 0, 0, 2001, 0, 5, 0, 0, 0, 0),
                           1, fault(1, ST_ILL_VALUE, T_INPUTS)});
      dir_rows.push_back('{1, header_of(FC_READ_COILS, 0, 0, 0, 0, 0, 5, 0, 0, 0, 0),
                           1, fault(1, ST_ILL_VALUE, T_COILS)});
      dir_rows.push_back('{1, header_of(FC_READ_HOLDING, 0, 0, 65535, 1, 0, 5, 0, 0, 0, 0),
                           0, mbrv_rsp_type'(0)});
      dir_rows.push_back('{1, header_of(FC_READ_INREGS, 0, 0, 0, 125, 0, 5, 0, 0, 0, 0),
                           0, mbrv_rsp_type'(0)});
      dir_rows.push_back('{1, header_of(FC_READ_INREGS, 0, 0, 0, 126, 0, 5, 0, 0, 0, 0),
                           1, fault(1, ST_ILL_VALUE, T_INREGS)});
      dir_rows.push_back('{1, header_of(FC_READ_INREGS, 1, 0, 0, 126, 0, 5, 0, 0, 0, 0),
                           0, mbrv_rsp_type'(0)});
      dir_rows.push_back('{1, header_of(FC_WRITE_COIL, 0, 0, 99, 0, 0, 5, COIL_ON, 0, 0, 0),
                           0, mbrv_rsp_type'(0)});
      dir_rows.push_back('{1, header_of(FC_WRITE_COIL, 0, 0, 0, 0, 0, 5, 16'h1234, 0, 0, 0),
                           1, fault(1, ST_ILL_VALUE, T_COILS)});
      dir_rows.push_back('{1, header_of(FC_WRITE_COIL, 0, 0, 100, 0, 0, 5, 0, 0, 0, 0),
                           1, fault(1, ST_ILL_ADDR, T_COILS)});
      dir_rows.push_back('{1, header_of(FC_WRITE_REGS, 0, 0, 65413, 123, 246, 252, 0, 0, 0, 0),
                           0, mbrv_rsp_type'(0)});
      dir_rows.push_back('{1, header_of(FC_WRITE_COILS, 0, 0, 0, 10, 2, 8, 0, 0, 0, 0),
                           0, mbrv_rsp_type'(0)});
      dir_rows.push_back('{1, header_of(FC_WRITE_COILS, 0, 0, 0, 10, 3, 9, 0, 0, 0, 0),
                           1, fault(1, ST_ILL_VALUE, T_COILS)});
      dir_rows.push_back('{1, header_of(FC_WRITE_REGS, 0, 0, 0, 2, 4, 9, 0, 0, 0, 0),
                           1, fault(1, ST_ILL_VALUE, T_HOLDING)});
      dir_rows.push_back('{1, header_of(FC_READ_WRITE_REGS, 0, 1, 0, 121, 242, 252, 0, 0,
                           125, 0), 0, mbrv_rsp_type'(0)});
      dir_rows.push_back('{1, header_of(FC_READ_WRITE_REGS, 0, 0, 0, 1, 2, 12, 0, 0, 0, 0),
                           1, fault(1, ST_ILL_VALUE, T_HOLDING)});
      dir_rows.push_back('{1, header_of(FC_DIAGNOSTICS, 0, 0, 0, 0, 0, 5, 0, 0, 0, 16'hFFFF),
                           1, fault(1, ST_ILL_FUNC, T_COILS)});
      dir_rows.push_back('{1, header_of(FC_VENDOR, 0, 0, 0, 0, 0, 5, 0, 0, 0, 0),
                           1, fault(1, ST_ILL_FUNC, T_COILS)});
      dir_rows.push_back('{1, header_of(FC_TOP, 1, 1, 16'hFFFF, 16'hFFFF, 8'hFF, 253,
                           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                           1, fault(0, ST_ILL_FUNC, T_COILS)});
      // access refused by the masks
      dir_rows.push_back('{2, header_of(FC_READ_HOLDING, 0, 0, 0, 1, 0, 5, 0, 0, 0, 0),
                           1, fault(1, ST_ILL_FUNC, T_HOLDING)});
      dir_rows.push_back('{2, header_of(FC_WRITE_COIL, 0, 0, 0, 0, 0, 5, 0, 0, 0, 0),
                           1, fault(1, ST_ILL_FUNC, T_COILS)});
      dir_rows.push_back('{2, header_of(FC_READ_WRITE_REGS, 0, 0, 0, 1, 2, 12, 0, 0, 1, 0),
                           1, fault(1, ST_ILL_FUNC, T_HOLDING)});
      // counts above the address space
      dir_rows.push_back('{3, header_of(FC_READ_WRITE_REGS, 0, 0, 0, 1, 2, 12, 0, 65535, 1,
                           0), 1, fault(1, ST_ILL_FUNC, T_HOLDING)});
      dir_rows.push_back('{3, header_of(FC_WRITE_REGS, 0, 0, 65535, 123, 246, 252, 0, 0, 0,
                           0), 0, mbrv_rsp_type'(0)});
      dir_rows.push_back('{3, header_of(FC_READ_COILS, 0, 0, 65535, 2000, 0, 5, 0, 0, 0, 0),
                           1, fault(1, ST_ILL_FUNC, T_COILS)});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, settings switched only when idle
      cur_sel = 0;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].cfg_sel != cur_sel) begin
            drain();
            apply_config(cfg_sets[dir_rows[i].cfg_sel]);
            cur_sel = dir_rows[i].cfg_sel;
         end
         offer_header(dir_rows[i].hdr, dir_rows[i].known, dir_rows[i].verdict);
      end

      // random phases under new settings each
      burst_left = 0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         case (p)
            0: c = '{17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 4'hF, 4'hF};
            1: c = '{17'h0, 17'h0, 17'h0, 17'h0, 4'hF, 4'hF};
            default: begin
               c.coil_count        = random_count();
               c.input_bit_count   = random_count();
               c.input_reg_count   = random_count();
               c.holding_reg_count = random_count();
               c.read_allowed      = ($urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom);
               c.write_allowed     = ($urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom);
            end
         endcase
         apply_config(c);
         calm = (p % 3 == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold back until the pipeline is empty once
            if (p == 3 && n == PHASE_ITEMS / 2) drain();
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap = calm ? 0 : $urandom_range(0, 5);
               if (gap > 0) begin
                  req_chan.valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            burst_left--;
            offer_header(build_request(table_cfg), 0, mbrv_rsp_type'(0));
         end
      end

      drain();
      repeat (8) @(posedge clock);

      $display("%0d request beats, %0d result beats, %0d register settings",
               headers_sent, results_seen, settings_applied);
      $display("status mix: ok %0d, bad function %0d, bad address %0d, bad value %0d",
               status_seen[ST_OK], status_seen[ST_ILL_FUNC], status_seen[ST_ILL_ADDR],
               status_seen[ST_ILL_VALUE]);
      if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, verdict_q.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/mbrv_pkg.sv
hw/rtl/mbrv_req_if.sv
hw/rtl/mbrv_rsp_if.sv
hw/rtl/mbrv_csr.sv
hw/rtl/mbrv_check.sv
hw/rtl/modbus_request_validator_core.sv
sim/tb_modbus_request_validator_core.sv
